// ===== rtl/stts_pkg.sv =====
// Package: types and constants for the sorted time table search block.
`timescale 1ns / 1ps
package stts_pkg;

  localparam int MAX_LINES = 1024;
  localparam int ADDR_W    = 10;
  localparam int CNT_W     = 11;
  localparam int TIME_W    = 31;
  localparam int IN_TIME_W = 48;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LINES);

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_ORDER = 2'd2;

  typedef struct packed {
    logic [1:0]                  kind;
    logic signed [IN_TIME_W-1:0] time_value;
  } in_t;

  typedef struct packed {
    logic signed [CNT_W-1:0] current_line;
    logic                    line_changed;
    logic                    has_lines;
    logic [CNT_W-1:0]        entry_count;
    logic [1:0]              status;
  } out_t;

endpackage

// ===== rtl/sorted_time_table_search.sv =====
// Top level: sorted time table with upper-bound binary search.
//
// Input channel (in_valid_i, in_stall_o, in_i) carries items of kind clear,
// append or query with a signed 48-bit time. Output channel (out_valid_o,
// out_stall_i, out_o) returns exactly one result item per input item, in order.
// An item is taken when valid is high and stall is low.
// One item is processed at a time. Clear, append and the unused kind go from
// accept through the execute and done states to the output register. A query
// on a non-empty table also passes the search state before done: each search
// step is one read of the single-port table memory (read data registered),
// with the compare and the next address computed in the read-data cycle.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, the result holds and the following result
// waits in the block, which then stops taking items.
// Reset empties the table (count 0) and sets the current line to -1; the
// memory contents are not cleared, as only entries below the count are read.
`timescale 1ns / 1ps
module sorted_time_table_search (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  stts_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output stts_pkg::out_t out_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [stts_pkg::TIME_W-1:0] mem [stts_pkg::MAX_LINES];
  logic [stts_pkg::TIME_W-1:0] rd_q;
  logic                        rd_en;
  logic [stts_pkg::ADDR_W-1:0] rd_addr;
  logic                        wr_en;

  logic [1:0] state_q, state_d;
  logic [1:0] kind_q;
  logic [stts_pkg::TIME_W-1:0] tgt_q, tgt_d;
  logic [stts_pkg::TIME_W-1:0] last_q, last_d;
  logic [stts_pkg::CNT_W-1:0]  count_q, count_d;
  logic signed [stts_pkg::CNT_W-1:0] cur_q, cur_d;
  logic signed [stts_pkg::CNT_W-1:0] res_cur_q, res_cur_d;
  logic [1:0] stat_q, stat_d;
  logic [stts_pkg::CNT_W-1:0]  lo_q, lo_d, hix_q, hix_d;
  logic [stts_pkg::ADDR_W-1:0] mid_q;
  logic signed [stts_pkg::CNT_W-1:0] best_q, best_d;
  logic       out_valid_q, out_valid_d;
  stts_pkg::out_t out_q, out_d;
  logic       accept;
  logic       out_free;
  logic [stts_pkg::CNT_W:0]    sum;
  logic [stts_pkg::CNT_W-1:0]  lo_n, hix_n;
  logic signed [stts_pkg::CNT_W-1:0] best_n;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // saturate to 0..2^31-1
  always_comb begin
    if (in_i.time_value[stts_pkg::IN_TIME_W-1]) begin
      tgt_d = '0;
    end else if (|in_i.time_value[stts_pkg::IN_TIME_W-2:stts_pkg::TIME_W]) begin
      tgt_d = '1;
    end else begin
      tgt_d = in_i.time_value[stts_pkg::TIME_W-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    last_d      = last_q;
    cur_d       = cur_q;
    res_cur_d   = res_cur_q;
    stat_d      = stat_q;
    lo_d        = lo_q;
    hix_d       = hix_q;
    best_d      = best_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    rd_en       = 1'b0;
    rd_addr     = mid_q;
    wr_en       = 1'b0;
    sum         = '0;
    lo_n        = lo_q;
    hix_n       = hix_q;
    best_n      = best_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        stat_d    = stts_pkg::STAT_OK;
        res_cur_d = cur_q;
        state_d   = S_DONE;
        unique case (kind_q)
          stts_pkg::KIND_CLEAR: begin
            count_d   = '0;
            res_cur_d = -stts_pkg::CNT_W'(1);
          end
          stts_pkg::KIND_APPEND: begin
            if (count_q >= stts_pkg::MAX_CNT) begin
              stat_d = stts_pkg::STAT_FULL;
            end else if (count_q != '0 && tgt_q < last_q) begin
              stat_d = stts_pkg::STAT_ORDER;
            end else begin
              wr_en   = 1'b1;
              last_d  = tgt_q;
              count_d = count_q + stts_pkg::CNT_W'(1);
              if (count_q == '0) begin
                res_cur_d = '0;
              end
            end
          end
          stts_pkg::KIND_QUERY: begin
            if (count_q == '0) begin
              res_cur_d = -stts_pkg::CNT_W'(1);
            end else begin
              lo_d    = '0;
              hix_d   = count_q;
              best_d  = -stts_pkg::CNT_W'(1);
              sum     = {1'b0, count_q} - (stts_pkg::CNT_W + 1)'(1);
              rd_en   = 1'b1;
              rd_addr = sum[stts_pkg::ADDR_W:1];
              state_d = S_SRCH;
            end
          end
          default: ;
        endcase
      end
      S_SRCH: begin
        if (rd_q <= tgt_q) begin
          best_n = $signed({1'b0, mid_q});
          lo_n   = {1'b0, mid_q} + stts_pkg::CNT_W'(1);
        end else begin
          hix_n  = {1'b0, mid_q};
        end
        lo_d   = lo_n;
        hix_d  = hix_n;
        best_d = best_n;
        if (lo_n < hix_n) begin
          sum     = {1'b0, lo_n} + {1'b0, hix_n} - (stts_pkg::CNT_W + 1)'(1);
          rd_en   = 1'b1;
          rd_addr = sum[stts_pkg::ADDR_W:1];
        end else begin
          res_cur_d = best_n;
          state_d   = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.current_line = res_cur_q;
          out_d.line_changed = (res_cur_q != cur_q);
          out_d.has_lines    = (count_q != '0);
          out_d.entry_count  = count_q;
          out_d.status       = stat_q;
          cur_d              = res_cur_q;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // table memory: one write or one read per cycle, read data registered
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[stts_pkg::ADDR_W-1:0]] <= tgt_q;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cur_q       <= -stts_pkg::CNT_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= in_i.kind;
      tgt_q  <= tgt_d;
    end
    if (rd_en) begin
      mid_q <= rd_addr;
    end
    last_q    <= last_d;
    res_cur_q <= res_cur_d;
    stat_q    <= stat_d;
    lo_q      <= lo_d;
    hix_q     <= hix_d;
    best_q    <= best_d;
    out_q     <= out_d;
  end

endmodule

// ===== rtl/stts_checker.sv =====
// Checker: port-level properties of the sorted time table search block.
`timescale 1ns / 1ps
module stts_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input stts_pkg::out_t out_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("result changed while stalled");

  a_has_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.has_lines == (out_o.entry_count != '0))
    else $error("has_lines disagrees with entry_count");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.entry_count <= stts_pkg::MAX_CNT)
    else $error("entry_count above table size");

  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.current_line == -stts_pkg::CNT_W'(1)) ||
      (!out_o.current_line[stts_pkg::CNT_W-1] &&
       $unsigned(out_o.current_line) < out_o.entry_count))
    else $error("current_line outside table");

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted while previous item in progress");

endmodule

bind sorted_time_table_search stts_checker u_stts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);
